### hdl/awc_pkg.sv
package awc_pkg;

    localparam int SIZE_WIDTH_DEF = 19;
    localparam int RATE_W         = 8;
    localparam int DUR_W          = 21;
    localparam logic [DUR_W-1:0] DUR_SAT = {DUR_W{1'b1}};

    typedef enum logic [1:0] {
        CLASS_DSSS = 2'd0,
        CLASS_OFDM = 2'd1,
        CLASS_ERP  = 2'd2,
        CLASS_BAD  = 2'd3
    } awc_class_t;

    localparam logic [1:0] SPACING_20 = 2'd0;
    localparam logic [1:0] SPACING_10 = 2'd1;
    localparam logic [1:0] SPACING_5  = 2'd2;

    localparam logic [1:0] CFG_CLASS   = 2'd0;
    localparam logic [1:0] CFG_SPACING = 2'd1;
    localparam logic [1:0] CFG_RATE    = 2'd2;

    localparam logic [1:0] RESET_CLASS   = 2'd1;
    localparam logic [1:0] RESET_SPACING = 2'd0;
    localparam logic [RATE_W-1:0] RESET_RATE = 8'd24;

    typedef struct packed {
        awc_class_t        mod_class;
        logic [1:0]        spacing_code;
        logic [RATE_W-1:0] rate_quarter_mbps;
    } awc_cfg_t;

    typedef struct packed {
        logic [7:0] pre;
        logic [5:0] hdr;
        logic [4:0] slot;
        logic [7:0] rxd;
        logic [2:0] qshift;
        logic       erp;
        logic       bad;
    } awc_side_t;

endpackage

### hdl/awc_front.sv
module awc_front #(
    parameter int SIZE_WIDTH = awc_pkg::SIZE_WIDTH_DEF,
    parameter int NUM_W      = SIZE_WIDTH + 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  awc_pkg::awc_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SIZE_WIDTH-1:0]         payload_bits,
    input  logic                          short_preamble,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [NUM_W-1:0]              out_num,
    output logic [awc_pkg::RATE_W-1:0]    out_den,
    output awc_pkg::awc_side_t            out_side
);
    import awc_pkg::*;

    logic                valid_reg;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [RATE_W-1:0]   den_reg, den_next;
    awc_side_t           side_reg, side_next;
    logic                ready;
    logic [NUM_W-1:0]    bits_ext, ofdm_x4, rnd, base;
    logic [2:0]          lg;

    assign ready    = !valid_reg || !out_stall;
    assign in_stall = !ready;

    always_comb
    begin
        bits_ext  = NUM_W'(payload_bits);
        ofdm_x4   = (bits_ext + NUM_W'(22)) << 2;
        den_next  = (cfg.rate_quarter_mbps == '0) ? RATE_W'(1) : cfg.rate_quarter_mbps;
        side_next = '0;
        lg        = 3'd2;
        rnd       = NUM_W'(3);
        base      = '0;
        unique case (cfg.mod_class)
            CLASS_DSSS:
            begin
                side_next.pre  = short_preamble ? 8'd72 : 8'd144;
                side_next.hdr  = short_preamble ? 6'd24 : 6'd48;
                side_next.slot = 5'd20;
                side_next.rxd  = short_preamble ? 8'd96 : 8'd192;
                base           = bits_ext << 2;
            end
            CLASS_OFDM:
            begin
                case (cfg.spacing_code)
                    SPACING_10:
                    begin
                        lg = 3'd3; rnd = NUM_W'(7);
                        side_next.pre = 8'd32; side_next.hdr = 6'd8;
                        side_next.slot = 5'd13; side_next.rxd = 8'd49;
                    end
                    SPACING_5:
                    begin
                        lg = 3'd4; rnd = NUM_W'(15);
                        side_next.pre = 8'd64; side_next.hdr = 6'd16;
                        side_next.slot = 5'd21; side_next.rxd = 8'd97;
                    end
                    default:
                    begin
                        side_next.pre = 8'd16; side_next.hdr = 6'd4;
                        side_next.slot = 5'd9; side_next.rxd = 8'd25;
                    end
                endcase
                side_next.qshift = lg;
                base = (ofdm_x4 + rnd) >> lg;
            end
            CLASS_ERP:
            begin
                side_next.pre    = 8'd16;
                side_next.hdr    = 6'd4;
                side_next.slot   = short_preamble ? 5'd9 : 5'd20;
                side_next.rxd    = 8'd24;
                side_next.qshift = lg;
                side_next.erp    = 1'b1;
                base = (ofdm_x4 + rnd) >> lg;
            end
            default:
            begin
                side_next.bad = 1'b1;
                den_next      = RATE_W'(1);
            end
        endcase
        num_next = side_next.bad ? '0
                 : base + NUM_W'(den_next) - NUM_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

### hdl/awc_div.sv
module awc_div #(
    parameter int NUM_W = awc_pkg::SIZE_WIDTH_DEF + 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [NUM_W-1:0]              in_num,
    input  logic [awc_pkg::RATE_W-1:0]    in_den,
    input  awc_pkg::awc_side_t            in_side,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [NUM_W-1:0]              out_quo,
    output awc_pkg::awc_side_t            out_side
);
    import awc_pkg::*;

    logic                valid_reg [NUM_W];
    logic [NUM_W-1:0]    num_reg   [NUM_W];
    logic [RATE_W-1:0]   rem_reg   [NUM_W];
    logic [RATE_W-1:0]   den_reg   [NUM_W];
    awc_side_t           side_reg  [NUM_W];

    logic                src_valid [NUM_W+1];
    logic [NUM_W-1:0]    src_num   [NUM_W+1];
    logic [RATE_W-1:0]   src_rem   [NUM_W+1];
    logic [RATE_W-1:0]   src_den   [NUM_W+1];
    awc_side_t           src_side  [NUM_W+1];
    logic                ready     [NUM_W+1];

    assign src_valid[0] = in_valid;
    assign src_num[0]   = in_num;
    assign src_rem[0]   = '0;
    assign src_den[0]   = in_den;
    assign src_side[0]  = in_side;
    assign ready[NUM_W] = !out_stall;
    assign in_stall     = !ready[0];

    for (genvar j = 0; j < NUM_W; j++)
    begin : g_stage
        logic [RATE_W:0]   trial;
        logic              ge;
        logic [RATE_W:0]   diff;
        logic [RATE_W-1:0] rem_next;
        logic [NUM_W-1:0]  num_next;

        assign ready[j] = !valid_reg[j] || ready[j+1];

        always_comb
        begin
            trial    = {src_rem[j], src_num[j][NUM_W-1]};
            ge       = trial >= {1'b0, src_den[j]};
            diff     = trial - {1'b0, src_den[j]};
            rem_next = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            num_next = {src_num[j][NUM_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (ready[j])
                valid_reg[j] <= src_valid[j];
        end

        always_ff @(posedge clk)
        begin
            if (ready[j] && src_valid[j])
            begin
                num_reg[j]  <= num_next;
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= src_den[j];
                side_reg[j] <= src_side[j];
            end
        end

        assign src_valid[j+1] = valid_reg[j];
        assign src_num[j+1]   = num_reg[j];
        assign src_rem[j+1]   = rem_reg[j];
        assign src_den[j+1]   = den_reg[j];
        assign src_side[j+1]  = side_reg[j];
    end

    assign out_valid = src_valid[NUM_W];
    assign out_quo   = src_num[NUM_W];
    assign out_side  = src_side[NUM_W];

endmodule

### hdl/awc_back.sv
module awc_back #(
    parameter int NUM_W = awc_pkg::SIZE_WIDTH_DEF + 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [NUM_W-1:0]              in_quo,
    input  awc_pkg::awc_side_t            in_side,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [awc_pkg::DUR_W-1:0]     tx_total_us,
    output logic [7:0]                    preamble_us,
    output logic [5:0]                    header_us,
    output logic [awc_pkg::DUR_W-1:0]     payload_us,
    output logic [4:0]                    slot_us,
    output logic [7:0]                    rx_start_delay_us,
    output logic                          bad_class
);
    import awc_pkg::*;

    localparam int PAY_W = NUM_W + 5;
    localparam int CMP_W = (PAY_W > DUR_W + 1) ? PAY_W : DUR_W + 1;

    logic               p_valid_reg, o_valid_reg;
    logic [DUR_W-1:0]   p_pay_reg, p_pay_next;
    awc_side_t          p_side_reg;
    logic [DUR_W-1:0]   o_total_reg, o_total_next;
    logic [DUR_W-1:0]   o_pay_reg;
    awc_side_t          o_side_reg;
    logic               p_ready, o_ready;
    logic [PAY_W-1:0]   shifted, pay_wide;
    logic [CMP_W-1:0]   pay_cmp;
    logic [DUR_W:0]     total_wide;

    assign o_ready  = !o_valid_reg || !out_stall;
    assign p_ready  = !p_valid_reg || o_ready;
    assign in_stall = !p_ready;

    always_comb
    begin
        shifted  = PAY_W'(in_quo) << in_side.qshift;
        pay_wide = shifted + (in_side.erp ? PAY_W'(6) : PAY_W'(0));
        pay_cmp  = CMP_W'(pay_wide);
        p_pay_next = (pay_cmp > CMP_W'(DUR_SAT)) ? DUR_SAT : pay_cmp[DUR_W-1:0];
    end

    always_comb
    begin
        total_wide = {1'b0, p_pay_reg} + (DUR_W+1)'(p_side_reg.pre)
                   + (DUR_W+1)'(p_side_reg.hdr);
        o_total_next = total_wide[DUR_W] ? DUR_SAT : total_wide[DUR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
                p_valid_reg <= in_valid;
            if (o_ready)
                o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && in_valid)
        begin
            p_pay_reg  <= p_pay_next;
            p_side_reg <= in_side;
        end
        if (o_ready && p_valid_reg)
        begin
            o_total_reg <= o_total_next;
            o_pay_reg   <= p_pay_reg;
            o_side_reg  <= p_side_reg;
        end
    end

    assign out_valid         = o_valid_reg;
    assign tx_total_us       = o_total_reg;
    assign preamble_us       = o_side_reg.pre;
    assign header_us         = o_side_reg.hdr;
    assign payload_us        = o_pay_reg;
    assign slot_us           = o_side_reg.slot;
    assign rx_start_delay_us = o_side_reg.rxd;
    assign bad_class         = o_side_reg.bad;

endmodule

### hdl/wlan_frame_airtime_calc.sv
// 802.11 frame airtime calculator (DSSS, OFDM, ERP-OFDM).
// Input beat: payload_bits and short_preamble, taken when in_valid is high and
// in_stall is low. Output beat: total, preamble, header, payload, slot and
// rx-start-delay times in microseconds plus bad_class, presented on out_valid
// and held until out_stall is low.
// Configuration: cfg_write with cfg_index 0 (class), 1 (spacing), 2 (rate in
// 250 kbps units); write only while no beat is in flight.
// Throughput: one beat per cycle while the output is not held. The pipe is
// one front stage, then the restoring divider that retires one quotient bit
// per stage, then two back stages.
// Every stage holds one beat and fills a bubble ahead of it, so new beats are
// accepted while a result waits, until the whole pipe is full; a held output
// stops only the stages behind it.
// Reset empties the pipe and loads class OFDM, 20 MHz spacing, rate 24.
module wlan_frame_airtime_calc #(
    parameter int SIZE_WIDTH = awc_pkg::SIZE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [awc_pkg::RATE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SIZE_WIDTH-1:0]         payload_bits,
    input  logic                          short_preamble,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [awc_pkg::DUR_W-1:0]     tx_total_us,
    output logic [7:0]                    preamble_us,
    output logic [5:0]                    header_us,
    output logic [awc_pkg::DUR_W-1:0]     payload_us,
    output logic [4:0]                    slot_us,
    output logic [7:0]                    rx_start_delay_us,
    output logic                          bad_class
);
    import awc_pkg::*;

    localparam int NUM_W = SIZE_WIDTH + 3;

    awc_cfg_t          cfg_reg;
    logic              f_valid, f_stall;
    logic [NUM_W-1:0]  f_num;
    logic [RATE_W-1:0] f_den;
    awc_side_t         f_side;
    logic              d_valid, d_stall;
    logic [NUM_W-1:0]  d_quo;
    awc_side_t         d_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mod_class         <= awc_class_t'(RESET_CLASS);
            cfg_reg.spacing_code      <= RESET_SPACING;
            cfg_reg.rate_quarter_mbps <= RESET_RATE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CLASS:   cfg_reg.mod_class         <= awc_class_t'(cfg_data[1:0]);
                CFG_SPACING: cfg_reg.spacing_code      <= cfg_data[1:0];
                CFG_RATE:    cfg_reg.rate_quarter_mbps <= cfg_data;
                default:     ;
            endcase
        end
    end

    awc_front #(
        .SIZE_WIDTH (SIZE_WIDTH),
        .NUM_W      (NUM_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .payload_bits   (payload_bits),
        .short_preamble (short_preamble),
        .out_valid      (f_valid),
        .out_stall      (f_stall),
        .out_num        (f_num),
        .out_den        (f_den),
        .out_side       (f_side)
    );

    awc_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_stall  (f_stall),
        .in_num    (f_num),
        .in_den    (f_den),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_stall (d_stall),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    awc_back #(
        .NUM_W (NUM_W)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (d_valid),
        .in_stall          (d_stall),
        .in_quo            (d_quo),
        .in_side           (d_side),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .tx_total_us       (tx_total_us),
        .preamble_us       (preamble_us),
        .header_us         (header_us),
        .payload_us        (payload_us),
        .slot_us           (slot_us),
        .rx_start_delay_us (rx_start_delay_us),
        .bad_class         (bad_class)
    );

endmodule
